### rtl/rmscg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmscg_pkg: shared types and constants for the rms compressor gain block
// Holds the sequencer op codes, controller states, command struct,
// register indexes and the fixed-point constants of the gain path.
// ----------------------------------------------------------------------------
package rmscg_pkg;

   // width of the iteration counter in the controller
   localparam int CNT_W = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 24;

   // fixed-point constants
   localparam logic [24:0] UNITY_GAIN = 25'd16777216;
   localparam logic signed [16:0] DB_FLOOR = -17'sd36864;
   localparam logic [16:0] DB_FLOOR_MAG = 17'd36864;
   localparam logic [31:0] DB_PER_LOG2_Q16 = 32'd197283;
   localparam logic [31:0] LOG2_10_OVER_20_Q24 = 32'd2786635;
   localparam logic [31:0] LN2_Q30 = 32'd744261118;
   localparam logic [30:0] ONE_Q30 = 31'd1073741824;
   localparam int LOG_FRAC_BITS = 16;
   localparam int SERIES_TERMS = 9;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACK = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOPE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAKEUP = 3'd4;

   // datapath operations, one per cycle; OP_NONE while the sequencer waits
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQ,
      OP_TAV,
      OP_E_HI,
      OP_E_LO,
      OP_S_HI,
      OP_S_LO,
      OP_ENV_WB,
      OP_NORM,
      OP_MINIT,
      OP_LSQ,
      OP_LUPD,
      OP_DBMUL,
      OP_DBWB,
      OP_GMUL,
      OP_EMUL,
      OP_EWB,
      OP_YMUL,
      OP_YWB,
      OP_HMUL,
      OP_HDIV,
      OP_HQ,
      OP_GFIN,
      OP_WSEL,
      OP_SM1,
      OP_SM2,
      OP_SMWB,
      OP_OM1,
      OP_OM2,
      OP_OUT
   } op_type;

   // controller states
   typedef enum logic [4:0] {
      S_IDLE,
      S_SQ,
      S_TAV,
      S_E_HI,
      S_E_LO,
      S_S_HI,
      S_S_LO,
      S_ENV_WB,
      S_NORM,
      S_MINIT,
      S_LSQ,
      S_LUPD,
      S_DBMUL,
      S_DBWB,
      S_GMUL,
      S_EMUL,
      S_EWB,
      S_YMUL,
      S_YWB,
      S_HMUL,
      S_HDIV,
      S_HQ,
      S_GFIN,
      S_WSEL,
      S_SM1,
      S_SM2,
      S_SMWB,
      S_OM1,
      S_OM2,
      S_OUT
   } state_type;

   // command from controller to datapath
   typedef struct packed {
      op_type op;
      logic [CNT_W-1:0] idx;
   } cmd_type;

   // floor(2^32/k) for the series divisors; k of one bypasses the multiply
   function automatic logic [31:0] div_recip(logic [CNT_W-1:0] k);
      logic [31:0] r;
      case (k)
         4'd2: r = 32'd2147483648;
         4'd3: r = 32'd1431655765;
         4'd4: r = 32'd1073741824;
         4'd5: r = 32'd858993459;
         4'd6: r = 32'd715827882;
         4'd7: r = 32'd613566756;
         4'd8: r = 32'd536870912;
         4'd9: r = 32'd477218588;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

### rtl/rmscg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmscg_ctrl: sequencer for the rms compressor gain block
// Walks one item through the datapath op by op, counts the loop passes
// and owns the input ready and the result valid.
// ----------------------------------------------------------------------------
module rmscg_ctrl #(
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rmscg_pkg::cmd_type cmd
);

   localparam int NORM_STEPS = $clog2(2 * SAMPLE_WIDTH);
   localparam logic [rmscg_pkg::CNT_W-1:0] NORM_LAST =
      rmscg_pkg::CNT_W'(NORM_STEPS - 1);
   localparam logic [rmscg_pkg::CNT_W-1:0] LOG_LAST =
      rmscg_pkg::CNT_W'(rmscg_pkg::LOG_FRAC_BITS - 1);
   localparam logic [rmscg_pkg::CNT_W-1:0] SERIES_FIRST =
      rmscg_pkg::CNT_W'(rmscg_pkg::SERIES_TERMS);

   rmscg_pkg::state_type state_ff, state_in;
   logic [rmscg_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_fire;

   // state, counter and result valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmscg_pkg::S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and command
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd.op = rmscg_pkg::OP_NONE;
      cmd.idx = cnt_ff;
      out_fire = 1'b0;
      case (state_ff)
         rmscg_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.op = rmscg_pkg::OP_LOAD;
               state_in = rmscg_pkg::S_SQ;
            end
         end
         rmscg_pkg::S_SQ: begin
            cmd.op = rmscg_pkg::OP_SQ;
            state_in = rmscg_pkg::S_TAV;
         end
         rmscg_pkg::S_TAV: begin
            cmd.op = rmscg_pkg::OP_TAV;
            state_in = rmscg_pkg::S_E_HI;
         end
         rmscg_pkg::S_E_HI: begin
            cmd.op = rmscg_pkg::OP_E_HI;
            state_in = rmscg_pkg::S_E_LO;
         end
         rmscg_pkg::S_E_LO: begin
            cmd.op = rmscg_pkg::OP_E_LO;
            state_in = rmscg_pkg::S_S_HI;
         end
         rmscg_pkg::S_S_HI: begin
            cmd.op = rmscg_pkg::OP_S_HI;
            state_in = rmscg_pkg::S_S_LO;
         end
         rmscg_pkg::S_S_LO: begin
            cmd.op = rmscg_pkg::OP_S_LO;
            state_in = rmscg_pkg::S_ENV_WB;
         end
         rmscg_pkg::S_ENV_WB: begin
            cmd.op = rmscg_pkg::OP_ENV_WB;
            cnt_in = NORM_LAST;
            state_in = rmscg_pkg::S_NORM;
         end
         rmscg_pkg::S_NORM: begin
            cmd.op = rmscg_pkg::OP_NORM;
            if (cnt_ff == '0) begin
               state_in = rmscg_pkg::S_MINIT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         rmscg_pkg::S_MINIT: begin
            cmd.op = rmscg_pkg::OP_MINIT;
            cnt_in = LOG_LAST;
            state_in = rmscg_pkg::S_LSQ;
         end
         rmscg_pkg::S_LSQ: begin
            cmd.op = rmscg_pkg::OP_LSQ;
            state_in = rmscg_pkg::S_LUPD;
         end
         rmscg_pkg::S_LUPD: begin
            cmd.op = rmscg_pkg::OP_LUPD;
            if (cnt_ff == '0) begin
               state_in = rmscg_pkg::S_DBMUL;
            end else begin
               cnt_in = cnt_ff - 1'b1;
               state_in = rmscg_pkg::S_LSQ;
            end
         end
         rmscg_pkg::S_DBMUL: begin
            cmd.op = rmscg_pkg::OP_DBMUL;
            state_in = rmscg_pkg::S_DBWB;
         end
         rmscg_pkg::S_DBWB: begin
            cmd.op = rmscg_pkg::OP_DBWB;
            state_in = rmscg_pkg::S_GMUL;
         end
         rmscg_pkg::S_GMUL: begin
            cmd.op = rmscg_pkg::OP_GMUL;
            state_in = rmscg_pkg::S_EMUL;
         end
         rmscg_pkg::S_EMUL: begin
            cmd.op = rmscg_pkg::OP_EMUL;
            state_in = rmscg_pkg::S_EWB;
         end
         rmscg_pkg::S_EWB: begin
            cmd.op = rmscg_pkg::OP_EWB;
            state_in = rmscg_pkg::S_YMUL;
         end
         rmscg_pkg::S_YMUL: begin
            cmd.op = rmscg_pkg::OP_YMUL;
            state_in = rmscg_pkg::S_YWB;
         end
         rmscg_pkg::S_YWB: begin
            cmd.op = rmscg_pkg::OP_YWB;
            cnt_in = SERIES_FIRST;
            state_in = rmscg_pkg::S_HMUL;
         end
         rmscg_pkg::S_HMUL: begin
            cmd.op = rmscg_pkg::OP_HMUL;
            state_in = rmscg_pkg::S_HDIV;
         end
         rmscg_pkg::S_HDIV: begin
            cmd.op = rmscg_pkg::OP_HDIV;
            state_in = rmscg_pkg::S_HQ;
         end
         rmscg_pkg::S_HQ: begin
            cmd.op = rmscg_pkg::OP_HQ;
            if (cnt_ff == rmscg_pkg::CNT_W'(1)) begin
               state_in = rmscg_pkg::S_GFIN;
            end else begin
               cnt_in = cnt_ff - 1'b1;
               state_in = rmscg_pkg::S_HMUL;
            end
         end
         rmscg_pkg::S_GFIN: begin
            cmd.op = rmscg_pkg::OP_GFIN;
            state_in = rmscg_pkg::S_WSEL;
         end
         rmscg_pkg::S_WSEL: begin
            cmd.op = rmscg_pkg::OP_WSEL;
            state_in = rmscg_pkg::S_SM1;
         end
         rmscg_pkg::S_SM1: begin
            cmd.op = rmscg_pkg::OP_SM1;
            state_in = rmscg_pkg::S_SM2;
         end
         rmscg_pkg::S_SM2: begin
            cmd.op = rmscg_pkg::OP_SM2;
            state_in = rmscg_pkg::S_SMWB;
         end
         rmscg_pkg::S_SMWB: begin
            cmd.op = rmscg_pkg::OP_SMWB;
            state_in = rmscg_pkg::S_OM1;
         end
         rmscg_pkg::S_OM1: begin
            cmd.op = rmscg_pkg::OP_OM1;
            state_in = rmscg_pkg::S_OM2;
         end
         rmscg_pkg::S_OM2: begin
            cmd.op = rmscg_pkg::OP_OM2;
            state_in = rmscg_pkg::S_OUT;
         end
         rmscg_pkg::S_OUT: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op = rmscg_pkg::OP_OUT;
               out_fire = 1'b1;
               state_in = rmscg_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rmscg_pkg::S_IDLE;
         end
      endcase
   end

   // result valid holds until taken
   assign rsp_valid_in = out_fire || (rsp_valid_ff && !rsp_ready);

   assign req_ready = (state_ff == rmscg_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/rmscg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmscg_dp: datapath of the rms compressor gain block
// Configuration registers, envelope and gain state, and one shared
// 32x32 multiplier with a registered product, driven op by op.
// ----------------------------------------------------------------------------
module rmscg_dp #(
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic clock,
   input  logic reset,
   input  rmscg_pkg::cmd_type cmd,
   input  logic csr_write,
   input  logic [rmscg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rmscg_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic signed [SAMPLE_WIDTH-1:0] req_detect_sample,
   input  logic signed [SAMPLE_WIDTH-1:0] req_delayed_sample,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_out_sample,
   output logic [24:0] rsp_applied_gain
);

   localparam int SW = SAMPLE_WIDTH;
   localparam int EW = 2 * SAMPLE_WIDTH;
   localparam int LZW = $clog2(EW) + 1;
   localparam logic [36:0] POS_LIMIT = 37'((64'd1 << (SW - 1)) - 64'd1);
   localparam logic [36:0] NEG_LIMIT = 37'(64'd1 << (SW - 1));

   // configuration registers
   logic [23:0] att_ff, rel_ff, mk_ff;
   logic [15:0] slope_ff, thr_ff;

   // item and state registers
   logic [SW-1:0] ad_ff, xs_ff;
   logic [EW-1:0] env_ff, sq_ff, acc_ff, norm_ff;
   logic [LZW-1:0] lz_ff;
   logic env_zero_ff;
   logic [24:0] wgt_ff, f_ff, sg_ff;
   logic [30:0] m_ff, r_ff, x_ff;
   logic [15:0] frac_ff, ef_ff;
   logic signed [16:0] db_ff;
   logic active_ff, big_ff;
   logic [4:0] n_ff;
   logic [29:0] y_ff;
   logic [49:0] sacc_ff;
   logic [63:0] prod_ff;
   logic signed [SW-1:0] out_ff;
   logic [24:0] gain_out_ff;

   // combinational helpers
   logic [31:0] mul_a, mul_b;
   logic mul_en;
   logic [63:0] env64, sq64;
   logic [SW-1:0] xs_mag, ad_in;
   logic [LZW-1:0] nsh, ntop;
   logic norm_top_zero;
   logic [21:0] neg_db;
   logic [40:0] db_sum;
   logic [16:0] db_raw;
   logic signed [17:0] thr18, db18, diff18;
   logic [17:0] diff_mag;
   logic [15:0] slope_mag;
   logic [54:0] e_sum;
   logic [29:0] e_val;
   logic [33:0] lsq_t;
   logic [30:0] q0, q1;
   logic [34:0] q0k, rem;
   logic [5:0] gshift;
   logic [31:0] gsum, gval;
   logic [24:0] f_new;
   logic [50:0] sm_sum;
   logic [26:0] sm_val;
   logic [57:0] om_sum;
   logic [31:0] om_round;
   logic [56:0] out_sum;
   logic [36:0] out_mag;
   logic [36:0] out_sat;
   logic [EW-1:0] prod_q24;

   // configuration writes, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         att_ff <= 24'd16760000;
         rel_ff <= 24'd16776000;
         slope_ff <= '0;
         thr_ff <= '0;
         mk_ff <= 24'd1048576;
      end else if (csr_write) begin
         case (csr_index)
            rmscg_pkg::CSR_ATTACK: att_ff <= csr_data;
            rmscg_pkg::CSR_RELEASE: rel_ff <= csr_data;
            rmscg_pkg::CSR_SLOPE: slope_ff <= csr_data[15:0];
            rmscg_pkg::CSR_THRESHOLD: thr_ff <= csr_data[15:0];
            rmscg_pkg::CSR_MAKEUP: mk_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // operand helpers
   assign env64 = 64'(env_ff);
   assign sq64 = 64'(sq_ff);
   assign ad_in = req_detect_sample[SW-1] ? (~req_detect_sample + 1'b1) : req_detect_sample;
   assign xs_mag = xs_ff[SW-1] ? (~xs_ff + 1'b1) : xs_ff;
   assign neg_db = {6'(lz_ff - 1'b1), 16'd0} - 22'(frac_ff);
   assign thr18 = 18'(signed'(thr_ff));
   assign db18 = 18'(db_ff);
   assign diff18 = thr18 - db18;
   assign diff_mag = diff18[17] ? 18'(-diff18) : 18'(diff18);
   assign slope_mag = slope_ff[15] ? (~slope_ff + 1'b1) : slope_ff;
   assign om_sum = 58'(prod_ff) + 58'd8388608;
   assign om_round = om_sum[55:24];
   // full product shifted down by 24, low bits truncated
   assign prod_q24 = EW'(prod_ff[63:24]);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      mul_en = 1'b1;
      case (cmd.op)
         rmscg_pkg::OP_SQ: begin
            mul_a = 32'(ad_ff);
            mul_b = 32'(ad_ff);
         end
         rmscg_pkg::OP_E_HI: begin
            mul_a = env64[63:32];
            mul_b = 32'(rmscg_pkg::UNITY_GAIN - wgt_ff);
         end
         rmscg_pkg::OP_E_LO: begin
            mul_a = env64[31:0];
            mul_b = 32'(rmscg_pkg::UNITY_GAIN - wgt_ff);
         end
         rmscg_pkg::OP_S_HI: begin
            mul_a = sq64[63:32];
            mul_b = 32'(wgt_ff);
         end
         rmscg_pkg::OP_S_LO: begin
            mul_a = sq64[31:0];
            mul_b = 32'(wgt_ff);
         end
         rmscg_pkg::OP_LSQ: begin
            mul_a = 32'(m_ff);
            mul_b = 32'(m_ff);
         end
         rmscg_pkg::OP_DBMUL: begin
            mul_a = 32'(neg_db);
            mul_b = rmscg_pkg::DB_PER_LOG2_Q16;
         end
         rmscg_pkg::OP_GMUL: begin
            mul_a = 32'(slope_mag);
            mul_b = 32'(diff_mag);
         end
         rmscg_pkg::OP_EMUL: begin
            mul_a = prod_ff[31:0];
            mul_b = rmscg_pkg::LOG2_10_OVER_20_Q24;
         end
         rmscg_pkg::OP_YMUL: begin
            mul_a = 32'(ef_ff);
            mul_b = rmscg_pkg::LN2_Q30;
         end
         rmscg_pkg::OP_HMUL: begin
            mul_a = 32'(y_ff);
            mul_b = 32'(r_ff);
         end
         rmscg_pkg::OP_HDIV: begin
            mul_a = 32'(prod_ff[60:30]);
            mul_b = rmscg_pkg::div_recip(cmd.idx);
         end
         rmscg_pkg::OP_SM1: begin
            mul_a = 32'(rmscg_pkg::UNITY_GAIN - wgt_ff);
            mul_b = 32'(f_ff);
         end
         rmscg_pkg::OP_SM2: begin
            mul_a = 32'(wgt_ff);
            mul_b = 32'(sg_ff);
         end
         rmscg_pkg::OP_OM1: begin
            mul_a = 32'(xs_mag);
            mul_b = 32'(sg_ff);
         end
         rmscg_pkg::OP_OM2: begin
            mul_a = om_round;
            mul_b = 32'(mk_ff);
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   // leading zero step, log squaring step, and level in dB
   always_comb begin
      nsh = LZW'(1) << cmd.idx;
      ntop = LZW'(EW) - nsh;
      norm_top_zero = ((norm_ff >> ntop) == '0);
      lsq_t = prod_ff[63:30];
      db_sum = prod_ff[40:0] + 41'd8388608;
      db_raw = db_sum[40:24];
      e_sum = prod_ff[54:0] + 55'd8388608;
      e_val = e_sum[53:24];
   end

   // series divide by k with one correction step
   always_comb begin
      q0 = (cmd.idx == rmscg_pkg::CNT_W'(1)) ? x_ff : prod_ff[62:32];
      q0k = 35'(q0) * 35'(cmd.idx);
      rem = 35'(x_ff) - q0k;
      q1 = (rem >= 35'(cmd.idx)) ? (q0 + 1'b1) : q0;
   end

   // target gain from the series result
   always_comb begin
      gshift = 6'(n_ff) + 6'd6;
      gsum = 32'(r_ff) + (32'd1 << (gshift - 6'd1));
      gval = gsum >> gshift;
      if (!active_ff) begin
         f_new = rmscg_pkg::UNITY_GAIN;
      end else if (big_ff) begin
         f_new = '0;
      end else if (gval > 32'(rmscg_pkg::UNITY_GAIN)) begin
         f_new = rmscg_pkg::UNITY_GAIN;
      end else begin
         f_new = gval[24:0];
      end
   end

   // gain smoothing sum and output rounding with saturation
   always_comb begin
      sm_sum = 51'(sacc_ff) + 51'(prod_ff[49:0]) + 51'd8388608;
      sm_val = sm_sum[50:24];
      out_sum = prod_ff[56:0] + 57'd524288;
      out_mag = out_sum[56:20];
      if (xs_ff[SW-1]) begin
         out_sat = (out_mag > NEG_LIMIT) ? NEG_LIMIT : out_mag;
      end else begin
         out_sat = (out_mag > POS_LIMIT) ? POS_LIMIT : out_mag;
      end
   end

   // product register
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= 64'(mul_a) * 64'(mul_b);
      end
   end

   // envelope and smoothed gain state
   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff <= '0;
         sg_ff <= rmscg_pkg::UNITY_GAIN;
      end else begin
         case (cmd.op)
            rmscg_pkg::OP_ENV_WB: env_ff <= acc_ff + prod_q24;
            rmscg_pkg::OP_SMWB: begin
               sg_ff <= (sm_val > 27'(rmscg_pkg::UNITY_GAIN)) ?
                        rmscg_pkg::UNITY_GAIN : sm_val[24:0];
            end
            default: ;
         endcase
      end
   end

   // working registers per op
   always_ff @(posedge clock) begin
      case (cmd.op)
         rmscg_pkg::OP_LOAD: begin
            ad_ff <= ad_in;
            xs_ff <= req_delayed_sample;
         end
         rmscg_pkg::OP_TAV: begin
            sq_ff <= prod_ff[EW-1:0];
            wgt_ff <= (env64 <= prod_ff) ? {1'b0, att_ff} : {1'b0, rel_ff};
         end
         rmscg_pkg::OP_E_LO: acc_ff <= EW'(prod_ff << 8);
         rmscg_pkg::OP_S_HI: acc_ff <= acc_ff + prod_q24;
         rmscg_pkg::OP_S_LO: acc_ff <= acc_ff + EW'(prod_ff << 8);
         rmscg_pkg::OP_ENV_WB: begin
            norm_ff <= acc_ff + prod_q24;
            env_zero_ff <= ((acc_ff + prod_q24) == '0);
            lz_ff <= '0;
         end
         rmscg_pkg::OP_NORM: begin
            if (norm_top_zero) begin
               norm_ff <= norm_ff << nsh;
               lz_ff <= lz_ff + nsh;
            end
         end
         rmscg_pkg::OP_MINIT: begin
            m_ff <= norm_ff[EW-1 -: 31];
            frac_ff <= '0;
         end
         rmscg_pkg::OP_LUPD: begin
            if (lsq_t[31]) begin
               m_ff <= lsq_t[31:1];
               frac_ff <= {frac_ff[14:0], 1'b1};
            end else begin
               m_ff <= lsq_t[30:0];
               frac_ff <= {frac_ff[14:0], 1'b0};
            end
         end
         rmscg_pkg::OP_DBWB: begin
            if (env_zero_ff || (db_raw > rmscg_pkg::DB_FLOOR_MAG)) begin
               db_ff <= rmscg_pkg::DB_FLOOR;
            end else begin
               db_ff <= -signed'(db_raw);
            end
         end
         rmscg_pkg::OP_GMUL: begin
            active_ff <= slope_ff[15] ? (db18 < thr18) : (db18 > thr18);
         end
         rmscg_pkg::OP_EWB: begin
            big_ff <= (e_val[29:16] > 14'd24);
            n_ff <= e_val[20:16];
            ef_ff <= e_val[15:0];
         end
         rmscg_pkg::OP_YWB: begin
            y_ff <= prod_ff[45:16];
            r_ff <= rmscg_pkg::ONE_Q30;
         end
         rmscg_pkg::OP_HDIV: x_ff <= prod_ff[60:30];
         rmscg_pkg::OP_HQ: r_ff <= rmscg_pkg::ONE_Q30 - q1;
         rmscg_pkg::OP_GFIN: f_ff <= f_new;
         rmscg_pkg::OP_WSEL: begin
            wgt_ff <= (f_ff < sg_ff) ? {1'b0, att_ff} : {1'b0, rel_ff};
         end
         rmscg_pkg::OP_SM2: sacc_ff <= prod_ff[49:0];
         rmscg_pkg::OP_OUT: begin
            out_ff <= xs_ff[SW-1] ? SW'(~out_sat + 1'b1) : SW'(out_sat);
            gain_out_ff <= sg_ff;
         end
         default: ;
      endcase
   end

   assign rsp_out_sample = out_ff;
   assign rsp_applied_gain = gain_out_ff;

endmodule

### rtl/rms_feedforward_compressor_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_feedforward_compressor_gain: one band of a feed-forward rms compressor
// Controller and datapath joined by a command struct; configuration port
// writes the weights, slope, threshold and makeup gain.
// ----------------------------------------------------------------------------
// One item at a time. The single shared 32x32 multiplier sets how long an item
// takes: it runs the envelope update, sixteen squaring passes of the log, the
// nine-term exponential series and the output scaling in turn. The result sits
// in an output register, so the next item is accepted while it waits to be
// taken. Configuration writes are always accepted and must only be made while
// the block is idle.
module rms_feedforward_compressor_gain #(
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_detect_sample,
   input  logic signed [SAMPLE_WIDTH-1:0] req_delayed_sample,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_out_sample,
   output logic [24:0] rsp_applied_gain,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [rmscg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rmscg_pkg::CSR_DATA_W-1:0] csr_data
);

   rmscg_pkg::cmd_type cmd;

   // configuration writes never stall
   assign csr_ready = 1'b1;

   // sequencer
   rmscg_ctrl #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd(cmd)
   );

   // arithmetic and state
   rmscg_dp #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .csr_write(csr_valid),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_detect_sample(req_detect_sample),
      .req_delayed_sample(req_delayed_sample),
      .rsp_out_sample(rsp_out_sample),
      .rsp_applied_gain(rsp_applied_gain)
   );

endmodule

### rtl/rmscg_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmscg_check: port-level checks for the rms compressor gain block
// Watches the handshakes and the reported gain; bound to the top level.
// ----------------------------------------------------------------------------
module rmscg_check #(
   parameter int SAMPLE_WIDTH = 24
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_out_sample,
   input logic [24:0] rsp_applied_gain
);

   // a stalled result stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its sample
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_sample))
      else $error("result sample changed while stalled");

   // reported gain never exceeds unity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_applied_gain <= rmscg_pkg::UNITY_GAIN)
      else $error("applied gain above unity");

   // one item at a time: busy right after an accepted item
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while busy");

endmodule

bind rms_feedforward_compressor_gain rmscg_check #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_rmscg_check (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_out_sample(rsp_out_sample),
   .rsp_applied_gain(rsp_applied_gain)
);
